// ===== rtl/srt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted ring table package
// Shared widths, operation and status codes, cell command and control states.
// ----------------------------------------------------------------------------
package srt_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int VALUE_W  = 32;
    localparam int OP_W     = 3;
    localparam int POS_W    = 16;
    localparam int STATUS_W = 2;

    // Remainder unit: bits retired per cycle and resulting cycle count.
    localparam int DIV_BITS_PER_CYC = 2;
    localparam int DIV_CYCLES       = POS_W / DIV_BITS_PER_CYC;

    localparam logic [OP_W-1:0] OP_INSERT      = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE_AT   = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE_NEXT = 3'd2;
    localparam logic [OP_W-1:0] OP_ADVANCE     = 3'd3;
    localparam logic [OP_W-1:0] OP_READ        = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE
    } cell_op_t;

    typedef struct packed {
        cell_op_t                   op;
        logic signed [VALUE_W-1:0]  value;
    } cell_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_APPLY,
        ST_FIXUP,
        ST_FINISH
    } ctrl_state_t;

endpackage

// ===== rtl/srt_cmd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel that carries one table operation per transfer.
// ----------------------------------------------------------------------------
interface srt_cmd_if
    import srt_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [OP_W-1:0]            operation;
    logic signed [VALUE_W-1:0]  item_value;
    logic [POS_W-1:0]           position_index;
    logic [POS_W-1:0]           shift_steps;

    modport source (
        output valid, operation, item_value, position_index, shift_steps,
        input  ready
    );

    modport sink (
        input  valid, operation, item_value, position_index, shift_steps,
        output ready
    );
endinterface

// ===== rtl/srt_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one result per transfer.
// ----------------------------------------------------------------------------
interface srt_rsp_if
    import srt_pkg::*;
#(
    parameter int CNT_W = $clog2(DEPTH_DEFAULT + 1)
) ();
    logic                       valid;
    logic                       ready;
    logic signed [VALUE_W-1:0]  read_value;
    logic [CNT_W-1:0]           entry_count;
    logic [STATUS_W-1:0]        status;

    modport source (
        output valid, read_value, entry_count, status,
        input  ready
    );

    modport sink (
        input  valid, read_value, entry_count, status,
        output ready
    );
endinterface

// ===== rtl/sorted_ring_table_with_cursor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted ring table with cursor
// Ascending table of signed values in a row of slots, with a cursor entry.
// ----------------------------------------------------------------------------
// Usage: each transfer on cmd carries one operation (insert, remove at index,
// remove after cursor, advance cursor, read); each produces exactly one
// transfer on rsp with the read value, the entry count and a status code.
// Commands are taken one at a time. Insert and remove shift the slots from
// the affected position onward one place, all slots at once; index and shift
// operands are reduced modulo the count by a remainder unit that retires two
// bits per cycle. A command passes through the accept, apply and finish
// steps; remove at index, advance and read on a non-empty table first wait
// for the remainder unit, and an insert into a non-empty, non-full table adds
// a cursor fixup step after apply.
// Results sit in an output register, so the next command is accepted and
// worked on while rsp is stalled; the block only waits when a second result
// is ready before the first has been taken.
// Reset empties the table and puts the cursor at 0; slot contents are not
// cleared and are never read before being written.
// ----------------------------------------------------------------------------
module sorted_ring_table_with_cursor
    import srt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    srt_cmd_if.sink   cmd,
    srt_rsp_if.source rsp
);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    ctrl_state_t               state_reg, state_next;
    logic [OP_W-1:0]           op_reg, op_next;
    logic signed [VALUE_W-1:0] value_reg, value_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [IDX_W-1:0]          cursor_reg, cursor_next;
    logic signed [VALUE_W-1:0] res_value_reg, res_value_next;
    logic [STATUS_W-1:0]       res_status_reg, res_status_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0] out_value_reg, out_value_next;
    logic [CNT_W-1:0]          out_count_reg, out_count_next;
    logic [STATUS_W-1:0]       out_status_reg, out_status_next;

    logic                      cmd_xfer;
    logic                      need_div;
    logic                      div_start;
    logic                      div_done;
    logic [CNT_W-1:0]          div_rem;
    logic [POS_W-1:0]          div_operand;

    cell_cmd_t                 cell_cmd;
    logic [IDX_W-1:0]          target;
    logic [IDX_W-1:0]          rem_k;
    logic [IDX_W-1:0]          next_k;
    logic [CNT_W-1:0]          cursor_inc;
    logic [SUM_W-1:0]          adv_sum;
    logic [SUM_W-1:0]          adv_wrap;
    logic [CNT_W-1:0]          count_m2;
    logic [IDX_W-1:0]          land_pos;
    logic                      pred_hit;
    logic signed [VALUE_W-1:0] rd_bus;

    logic signed [VALUE_W-1:0] slot_value [DEPTH];
    logic signed [VALUE_W-1:0] slot_rd    [DEPTH];
    logic signed [VALUE_W-1:0] left_value [DEPTH];
    logic signed [VALUE_W-1:0] right_value[DEPTH];
    logic [DEPTH-1:0]          slot_ge;
    logic [DEPTH-1:0]          left_ge;
    logic [DEPTH-1:0]          landed;

    // ------------------------------------------------------------------------
    // Row of slots
    // ------------------------------------------------------------------------
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_slot
        if (g == 0)
        begin : g_head
            assign left_value[g] = '0;
            assign left_ge[g]    = 1'b0;
        end
        else
        begin : g_body
            assign left_value[g] = slot_value[g-1];
            assign left_ge[g]    = slot_ge[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_tail
            assign right_value[g] = '0;
        end
        else
        begin : g_link
            assign right_value[g] = slot_value[g+1];
        end

        srt_cell #(
            .IDX   (g),
            .IDX_W (IDX_W),
            .CNT_W (CNT_W)
        ) u_slot (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cell_cmd),
            .count       (count_reg),
            .target      (target),
            .left_value  (left_value[g]),
            .left_ge     (left_ge[g]),
            .right_value (right_value[g]),
            .value       (slot_value[g]),
            .ge          (slot_ge[g]),
            .landed      (landed[g]),
            .rd_value    (slot_rd[g])
        );
    end

    always_comb
    begin
        rd_bus   = '0;
        land_pos = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rd_bus = rd_bus | slot_rd[i];
            if (landed[i])
            begin
                land_pos = land_pos | IDX_W'(i);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Index reduction
    // ------------------------------------------------------------------------
    assign cmd_xfer    = cmd.valid && cmd.ready;
    assign need_div    = (cmd.operation inside {OP_REMOVE_AT, OP_ADVANCE, OP_READ})
                         && (count_reg != '0);
    assign div_start   = cmd_xfer && need_div;
    assign div_operand = (cmd.operation == OP_ADVANCE) ? cmd.shift_steps
                                                       : cmd.position_index;

    srt_rem_unit #(
        .CNT_W (CNT_W)
    ) u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_operand),
        .divisor   (count_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign rem_k      = div_rem[IDX_W-1:0];
    assign cursor_inc = CNT_W'(cursor_reg) + CNT_W'(1);
    assign next_k     = (cursor_inc == count_reg) ? '0 : cursor_inc[IDX_W-1:0];
    assign adv_sum    = SUM_W'(cursor_reg) + SUM_W'(div_rem);
    assign adv_wrap   = (adv_sum >= SUM_W'(count_reg)) ? adv_sum - SUM_W'(count_reg)
                                                       : adv_sum;
    assign count_m2   = count_reg - CNT_W'(2);
    assign target     = (op_reg == OP_REMOVE_NEXT) ? next_k : rem_k;

    // After an insert the count already holds the new size, so the old last
    // index is count minus two.
    assign pred_hit = (land_pos == '0) ? (CNT_W'(cursor_reg) == count_m2)
                                       : (cursor_reg == land_pos - IDX_W'(1));

    // ------------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_xfer)
                begin
                    state_next = need_div ? ST_DIVIDE : ST_APPLY;
                end
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (op_reg == OP_INSERT && count_reg != '0
                    && count_reg < CNT_W'(DEPTH))
                begin
                    state_next = ST_FIXUP;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FIXUP:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        op_next         = op_reg;
        value_next      = value_reg;
        count_next      = count_reg;
        cursor_next     = cursor_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_value_next  = out_value_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;
        cell_cmd.op     = CELL_HOLD;
        cell_cmd.value  = value_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_xfer)
                begin
                    op_next    = cmd.operation;
                    value_next = cmd.item_value;
                end
            end
            ST_APPLY:
            begin
                res_value_next  = '0;
                res_status_next = STATUS_DONE;
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (count_reg >= CNT_W'(DEPTH))
                        begin
                            res_status_next = STATUS_FULL;
                        end
                        else
                        begin
                            cell_cmd.op = CELL_INSERT;
                            count_next  = count_reg + CNT_W'(1);
                            if (count_reg == '0)
                            begin
                                cursor_next = '0;
                            end
                        end
                    end
                    OP_REMOVE_AT, OP_REMOVE_NEXT:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = STATUS_EMPTY;
                        end
                        else if (count_reg == CNT_W'(1))
                        begin
                            count_next  = '0;
                            cursor_next = '0;
                        end
                        else
                        begin
                            cell_cmd.op = CELL_REMOVE;
                            count_next  = count_reg - CNT_W'(1);
                            // A removed cursor entry hands the cursor to its
                            // circular predecessor.
                            if (cursor_reg == target)
                            begin
                                cursor_next = (target == '0) ? count_m2[IDX_W-1:0]
                                                             : target - IDX_W'(1);
                            end
                            else if (cursor_reg > target)
                            begin
                                cursor_next = cursor_reg - IDX_W'(1);
                            end
                        end
                    end
                    OP_ADVANCE:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = STATUS_EMPTY;
                        end
                        else
                        begin
                            cursor_next = adv_wrap[IDX_W-1:0];
                        end
                    end
                    OP_READ:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = STATUS_EMPTY;
                        end
                        else
                        begin
                            res_value_next = rd_bus;
                        end
                    end
                    default:
                    begin
                        res_status_next = STATUS_DONE;
                    end
                endcase
            end
            ST_FIXUP:
            begin
                // The cursor follows its own entry, unless the new entry
                // landed right after it, in which case it takes the new one.
                if (pred_hit)
                begin
                    cursor_next = land_pos;
                end
                else if (cursor_reg >= land_pos)
                begin
                    cursor_next = cursor_reg + IDX_W'(1);
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = res_value_reg;
                    out_count_next  = count_reg;
                    out_status_next = res_status_reg;
                end
            end
            default:
            begin
                cell_cmd.op = CELL_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cursor_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cursor_reg    <= cursor_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        value_reg      <= value_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        out_value_reg  <= out_value_next;
        out_count_reg  <= out_count_next;
        out_status_reg <= out_status_next;
    end

    assign cmd.ready       = state_reg == ST_IDLE;
    assign rsp.valid       = out_valid_reg;
    assign rsp.read_value  = out_value_reg;
    assign rsp.entry_count = out_count_reg;
    assign rsp.status      = out_status_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds table depth");

    a_cursor_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (CNT_W'(cursor_reg) < count_reg))
        else $error("cursor points past the last entry");

    a_cursor_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (cursor_reg == '0))
        else $error("cursor not at zero in an empty table");

    a_single_landing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIXUP) |-> $onehot(landed))
        else $error("insert did not land in exactly one slot");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_FINISH))
        else $error("result appeared outside the finish step");

endmodule

// ===== rtl/srt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Table slot
// Holds one sorted entry and trades it with its neighbors on insert/remove.
// ----------------------------------------------------------------------------
module srt_cell
    import srt_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int IDX_W = 4,
    parameter int CNT_W = 5
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  cell_cmd_t                  cmd,
    input  logic [CNT_W-1:0]           count,
    input  logic [IDX_W-1:0]           target,
    input  logic signed [VALUE_W-1:0]  left_value,
    input  logic                       left_ge,
    input  logic signed [VALUE_W-1:0]  right_value,
    output logic signed [VALUE_W-1:0]  value,
    output logic                       ge,
    output logic                       landed,
    output logic signed [VALUE_W-1:0]  rd_value
);
    logic signed [VALUE_W-1:0] value_reg, value_next;
    logic                      landed_reg, landed_next;
    logic                      in_use;
    logic                      at_end;
    logic                      take_new;

    assign in_use = CNT_W'(IDX) < count;
    assign at_end = count == CNT_W'(IDX);

    // The slot moves right when the new value sorts before it. The head slot
    // only yields to a strictly smaller value, so a tie with it lands after it.
    assign ge = in_use && ((IDX == 0) ? (cmd.value < value_reg)
                                      : (value_reg >= cmd.value));

    assign take_new = !left_ge && (ge || at_end);

    always_comb
    begin
        value_next  = value_reg;
        landed_next = 1'b0;
        case (cmd.op)
            CELL_INSERT:
            begin
                if (left_ge)
                begin
                    value_next = left_value;
                end
                else if (take_new)
                begin
                    value_next  = cmd.value;
                    landed_next = 1'b1;
                end
            end
            CELL_REMOVE:
            begin
                if (IDX_W'(IDX) >= target && CNT_W'(IDX + 1) < count)
                begin
                    value_next = right_value;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            landed_reg <= 1'b0;
        end
        else
        begin
            landed_reg <= landed_next;
        end
    end

    assign value    = value_reg;
    assign landed   = landed_reg;
    assign rd_value = (IDX_W'(IDX) == target) ? value_reg : '0;

endmodule

// ===== rtl/srt_rem_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Remainder unit
// Restoring division of a 16-bit operand by the entry count, remainder only.
// ----------------------------------------------------------------------------
module srt_rem_unit
    import srt_pkg::*;
#(
    parameter int CNT_W = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [POS_W-1:0]  dividend,
    input  logic [CNT_W-1:0]  divisor,
    output logic              done,
    output logic [CNT_W-1:0]  remainder
);
    localparam int STEP_W = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [POS_W-1:0]  dvd_reg, dvd_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic              last_step;

    assign last_step = step_reg == STEP_W'(DIV_CYCLES - 1);

    always_comb
    begin
        logic [CNT_W:0]   trial;
        logic [CNT_W-1:0] rem_work;
        logic [POS_W-1:0] dvd_work;
        rem_work = rem_reg;
        dvd_work = dvd_reg;
        trial    = '0;
        for (int j = 0; j < DIV_BITS_PER_CYC; j++)
        begin
            trial = {rem_work, dvd_work[POS_W-1]};
            if (trial >= {1'b0, divisor})
            begin
                trial = trial - {1'b0, divisor};
            end
            rem_work = trial[CNT_W-1:0];
            dvd_work = {dvd_work[POS_W-2:0], 1'b0};
        end

        busy_next = busy_reg;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            dvd_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next  = dvd_work;
            rem_next  = rem_work;
            step_next = step_reg + STEP_W'(1);
            if (last_step)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done      = busy_reg && last_step;
    assign remainder = rem_reg;

endmodule

// ===== verif/tb_sorted_ring_table_with_cursor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted ring table with cursor testbench
// Drives table operations on the command channel and checks every result
// against a typed-in result or a shadow copy of the sorted table, its count
// and its cursor. A short table of directed operations covers the empty,
// single-entry and extreme-value cases. Random operations follow in grow,
// shrink and mixed phases so that the table fills up and drains again. Both
// channels idle at random, except during one long stretch.
// ----------------------------------------------------------------------------
module tb_sorted_ring_table_with_cursor;
    import srt_pkg::*;

    localparam int TABLE_DEPTH = DEPTH_DEFAULT;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int SCRIPT_LEN  = 23;
    localparam int PHASE_LEN   = 50;
    localparam int PHASES      = 33;

    // Codes above the read operation do nothing but report done.
    localparam logic [OP_W-1:0] OP_UNUSED_LO  = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_MID = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_HI  = 3'd7;

    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic [POS_W-1:0]          POS_MAX   = '1;

    typedef enum logic [1:0] {
        MIX_GROW,
        MIX_SHRINK,
        MIX_BALANCED
    } op_mix_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [CNT_W-1:0]          count;
        logic [STATUS_W-1:0]       status;
    } table_result_t;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          index;
        logic [POS_W-1:0]          steps;
        logic                      fixed;
        table_result_t             result;
    } script_row_t;

    logic clk;
    logic rst_n;

    srt_cmd_if cmd ();
    srt_rsp_if #(.CNT_W(CNT_W)) rsp ();

    sorted_ring_table_with_cursor #(
        .DEPTH(TABLE_DEPTH)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    // Shadow state of the table.
    logic signed [VALUE_W-1:0] shadow_entries [TABLE_DEPTH];
    int                        shadow_count;
    int                        shadow_cursor;

    table_result_t pending_results [$];
    int            mismatch_count;
    logic          no_gaps;

    // A directed row may carry its result typed in; it travels with the command.
    logic          cmd_fixed;
    table_result_t cmd_fixed_result;

    script_row_t script [SCRIPT_LEN];

    initial begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic void drop_entry(int k);
        int n;
        n = shadow_count;
        if (n <= 1)
        begin
            shadow_count  = 0;
            shadow_cursor = 0;
            return;
        end
        for (int i = k; i + 1 < n; i++)
            shadow_entries[i] = shadow_entries[i + 1];
        if (shadow_cursor == k)
            shadow_cursor = (k == 0) ? n - 2 : k - 1;
        else if (shadow_cursor > k)
            shadow_cursor = shadow_cursor - 1;
        shadow_count = n - 1;
    endfunction

    function automatic table_result_t apply_table_op(
        logic [OP_W-1:0]           op,
        logic signed [VALUE_W-1:0] val,
        logic [POS_W-1:0]          idx,
        logic [POS_W-1:0]          steps
    );
        table_result_t r;
        int            n;
        int            p;
        r.value  = '0;
        r.status = STATUS_DONE;
        n        = shadow_count;
        if (op == OP_INSERT)
        begin
            if (n >= TABLE_DEPTH)
                r.status = STATUS_FULL;
            else if (n == 0)
            begin
                shadow_entries[0] = val;
                shadow_cursor     = 0;
                shadow_count      = 1;
            end
            else
            begin
                // A value equal to the first entry lands after it.
                if (val < shadow_entries[0])
                    p = 0;
                else
                begin
                    p = 1;
                    while (p < n && shadow_entries[p] < val)
                        p++;
                end
                for (int i = n; i > p; i--)
                    shadow_entries[i] = shadow_entries[i - 1];
                shadow_entries[p] = val;
                if (shadow_cursor == (p + n - 1) % n)
                    shadow_cursor = p;
                else if (shadow_cursor >= p)
                    shadow_cursor = shadow_cursor + 1;
                shadow_count = n + 1;
            end
        end
        else if (op == OP_REMOVE_AT || op == OP_REMOVE_NEXT || op == OP_ADVANCE ||
                 op == OP_READ)
        begin
            if (n == 0)
                r.status = STATUS_EMPTY;
            else if (op == OP_REMOVE_AT)
                drop_entry(int'(idx) % n);
            else if (op == OP_REMOVE_NEXT)
                drop_entry((shadow_cursor + 1) % n);
            else if (op == OP_ADVANCE)
                shadow_cursor = (shadow_cursor + int'(steps) % n) % n;
            else
                r.value = shadow_entries[int'(idx) % n];
        end
        r.count = shadow_count[CNT_W-1:0];
        return r;
    endfunction

    task automatic check_field(string name, logic [VALUE_W-1:0] exp_val,
                               logic [VALUE_W-1:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    // Predict on each command transfer, check on each result transfer.
    always @(posedge clk)
    begin
        table_result_t predicted;
        table_result_t oldest;
        if (rst_n)
        begin
            if (cmd.valid && cmd.ready)
            begin
                predicted = apply_table_op(cmd.operation, cmd.item_value,
                                           cmd.position_index, cmd.shift_steps);
                pending_results.push_back(cmd_fixed ? cmd_fixed_result : predicted);
            end
            if (rsp.valid && rsp.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t ns: unexpected result, expected none, actual %0h %0d %0d",
                             $time, rsp.read_value, rsp.entry_count, rsp.status);
                    mismatch_count++;
                end
                else
                begin
                    oldest = pending_results.pop_front();
                    check_field("read_value", oldest.value, rsp.read_value);
                    check_field("entry_count", VALUE_W'(oldest.count), VALUE_W'(rsp.entry_count));
                    check_field("status", VALUE_W'(oldest.status), VALUE_W'(rsp.status));
                end
            end
        end
    end

    initial begin
        rsp.ready = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
            rsp.ready <= no_gaps || ($urandom_range(0, 99) >= 29);
    end

    task automatic send_op(logic [OP_W-1:0] op, logic signed [VALUE_W-1:0] val,
                           logic [POS_W-1:0] idx, logic [POS_W-1:0] steps,
                           logic fixed, table_result_t fixed_result);
        if (!no_gaps && $urandom_range(0, 99) < 29)
        begin
            cmd.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < 29)
                @(posedge clk);
        end
        cmd.valid          <= 1'b1;
        cmd.operation      <= op;
        cmd.item_value     <= val;
        cmd.position_index <= idx;
        cmd.shift_steps    <= steps;
        cmd_fixed          <= fixed;
        cmd_fixed_result   <= fixed_result;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        // Narrow values produce plenty of duplicates and ties with the first entry.
        if (sel < 5)
            return VALUE_W'(int'($urandom_range(0, 16)) - 8);
        else if (sel < 8)
            return $urandom;
        else if (sel == 8)
            return VALUE_MAX;
        else
            return VALUE_MIN;
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        if ($urandom_range(0, 99) < 70)
            return POS_W'($urandom_range(0, 20));
        return POS_W'($urandom_range(0, 65535));
    endfunction

    initial begin
        op_mix_t         mix;
        int              insert_pct;
        int              remove_pct;
        int              roll;
        int              guard;
        logic [OP_W-1:0] op;
        table_result_t   no_result;

        no_result = '0;
        script = '{
            '{OP_READ,        32'sd0,    16'd0,   16'd0,   1'b1, '{32'sd0, 5'd0, STATUS_EMPTY}},
            '{OP_REMOVE_AT,   32'sd0,    POS_MAX, 16'd0,   1'b1, '{32'sd0, 5'd0, STATUS_EMPTY}},
            '{OP_REMOVE_NEXT, 32'sd0,    16'd0,   16'd0,   1'b1, '{32'sd0, 5'd0, STATUS_EMPTY}},
            '{OP_ADVANCE,     32'sd0,    16'd0,   POS_MAX, 1'b1, '{32'sd0, 5'd0, STATUS_EMPTY}},
            '{OP_UNUSED_LO,   VALUE_MAX, POS_MAX, POS_MAX, 1'b1, '{32'sd0, 5'd0, STATUS_DONE}},
            '{OP_INSERT,      32'sd42,   16'd0,   16'd0,   1'b1, '{32'sd0, 5'd1, STATUS_DONE}},
            '{OP_REMOVE_NEXT, 32'sd0,    16'd0,   16'd0,   1'b1, '{32'sd0, 5'd0, STATUS_DONE}},
            '{OP_INSERT,      VALUE_MAX, 16'd0,   16'd0,   1'b1, '{32'sd0, 5'd1, STATUS_DONE}},
            '{OP_READ,        32'sd0,    POS_MAX, 16'd0,   1'b1, '{VALUE_MAX, 5'd1, STATUS_DONE}},
            '{OP_INSERT,      VALUE_MIN, 16'd0,   16'd0,   1'b1, '{32'sd0, 5'd2, STATUS_DONE}},
            '{OP_READ,        32'sd0,    16'd0,   16'd0,   1'b1, '{VALUE_MIN, 5'd2, STATUS_DONE}},
            '{OP_INSERT,      VALUE_MIN, 16'd0,   16'd0,   1'b0, no_result},
            '{OP_INSERT,      32'sd0,    16'd0,   16'd0,   1'b0, no_result},
            '{OP_INSERT,      -32'sd1,   16'd0,   16'd0,   1'b0, no_result},
            '{OP_READ,        32'sd0,    16'd1,   16'd0,   1'b0, no_result},
            '{OP_ADVANCE,     32'sd0,    16'd0,   POS_MAX, 1'b0, no_result},
            '{OP_REMOVE_NEXT, 32'sd0,    16'd0,   16'd0,   1'b0, no_result},
            '{OP_READ,        32'sd0,    16'hAAAA, 16'd0,  1'b0, no_result},
            '{OP_ADVANCE,     32'sd0,    16'd0,   16'h5555, 1'b0, no_result},
            '{OP_REMOVE_AT,   32'sd0,    POS_MAX, 16'd0,   1'b0, no_result},
            '{OP_UNUSED_MID,  32'sd0,    16'd0,   16'd0,   1'b0, no_result},
            '{OP_UNUSED_HI,   32'sd0,    16'd0,   16'd0,   1'b0, no_result},
            '{OP_REMOVE_AT,   32'sd0,    16'd0,   16'd0,   1'b0, no_result}
        };

        shadow_count       = 0;
        shadow_cursor      = 0;
        mismatch_count     = 0;
        no_gaps            = 1'b0;
        cmd_fixed          = 1'b0;
        cmd_fixed_result   = '0;
        cmd.valid          = 1'b0;
        cmd.operation      = OP_INSERT;
        cmd.item_value     = '0;
        cmd.position_index = '0;
        cmd.shift_steps    = '0;
        rst_n              = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
            send_op(script[i].op, script[i].value, script[i].index, script[i].steps,
                    script[i].fixed, script[i].result);

        // Phases cycle through filling, draining and balanced mixes, so both the
        // full and the empty cases recur many times.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            no_gaps <= (ph >= 12 && ph < 18);
            if (ph % 3 == 0)
                mix = MIX_GROW;
            else if (ph % 3 == 1)
                mix = MIX_SHRINK;
            else
                mix = MIX_BALANCED;
            case (mix)
                MIX_GROW:
                begin
                    insert_pct = 70;
                    remove_pct = 12;
                end
                MIX_SHRINK:
                begin
                    insert_pct = 15;
                    remove_pct = 65;
                end
                default:
                begin
                    insert_pct = 35;
                    remove_pct = 30;
                end
            endcase
            for (int k = 0; k < PHASE_LEN; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < insert_pct)
                    op = OP_INSERT;
                else if (roll < insert_pct + remove_pct)
                    op = $urandom_range(0, 1) ? OP_REMOVE_AT : OP_REMOVE_NEXT;
                else if (roll < 97)
                    op = $urandom_range(0, 1) ? OP_READ : OP_ADVANCE;
                else
                    op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
                send_op(op, pick_value(), pick_position(), pick_position(), 1'b0, no_result);
            end
        end
        cmd.valid <= 1'b0;
        no_gaps   <= 1'b0;

        guard = 0;
        while (pending_results.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (20) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0t ns: results missing, expected %0d more, actual 0",
                     $time, pending_results.size());
            mismatch_count++;
        end

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/srt_pkg.sv
rtl/srt_cmd_if.sv
rtl/srt_rsp_if.sv
rtl/srt_cell.sv
rtl/srt_rem_unit.sv
rtl/sorted_ring_table_with_cursor.sv
verif/tb_sorted_ring_table_with_cursor.sv
